### design/tfn_pkg.sv
// ---------------------------------------------------------------------------
// tfn_pkg
// Shared widths, constants and types for the triangle face unit normal block.
// ---------------------------------------------------------------------------
package tfn_pkg;

    // vertex coordinate, Q4.12
    localparam int CoordW   = 16;
    // edge component, Q5.12
    localparam int EdgeW    = CoordW + 1;
    // edge product, Q10.24
    localparam int ProdW    = 2 * EdgeW;
    // cross product component, signed
    localparam int CrossW   = ProdW + 1;
    // cross product magnitude, below 2^33
    localparam int MagW     = ProdW;
    // normalized magnitude, max lands in [2^29, 2^30)
    localparam int NormW    = 30;
    localparam int NormTop  = NormW - 1;
    localparam int ShiftW   = 6;
    localparam int SqW      = 2 * NormW;
    localparam int SumW     = SqW + 2;
    localparam int RootW    = SumW / 2;
    localparam int RemW     = RootW + 2;
    // unit output, Q1.14
    localparam int FracBits = 14;
    localparam int UnitW    = 16;
    localparam int QuotW    = 16;
    localparam int NumW     = NormW + FracBits + 1;
    localparam int DivRemW  = RootW + 1;
    localparam logic [UnitW-1:0] UnitOne = 16'd16384;

    // item data that rides alongside the square root and divide
    typedef struct packed {
        logic [2:0]            neg;
        logic                  degen;
        logic [2:0][NormW-1:0] m;
    } tfn_side_t;

endpackage

### design/tfn_cross.sv
// ---------------------------------------------------------------------------
// tfn_cross
// Edge vectors, cross product and component magnitudes in three stages.
// ---------------------------------------------------------------------------
module tfn_cross
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  en,
    input  logic                                  vld_in,
    input  logic [8:0][tfn_pkg::CoordW-1:0]       pts,
    output logic                                  vld_out,
    output logic [2:0][tfn_pkg::MagW-1:0]         mag,
    output logic [2:0]                            neg
);
    import tfn_pkg::*;

    logic signed [EdgeW-1:0]  a_reg [3];
    logic signed [EdgeW-1:0]  b_reg [3];
    logic signed [EdgeW-1:0]  a_next [3];
    logic signed [EdgeW-1:0]  b_next [3];
    logic signed [ProdW-1:0]  prod_reg [6];
    logic signed [CrossW-1:0] n_next [3];
    logic [2:0][MagW-1:0]     mag_reg;
    logic [2:0]               neg_reg;
    logic [2:0]               vld_reg;

    // edge vectors a = p1 - p0, b = p2 - p1
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            a_next[i] = $signed({pts[3+i][CoordW-1], pts[3+i]})
                      - $signed({pts[i][CoordW-1], pts[i]});
            b_next[i] = $signed({pts[6+i][CoordW-1], pts[6+i]})
                      - $signed({pts[3+i][CoordW-1], pts[3+i]});
        end
    end

    // cross product differences
    always_comb
    begin
        n_next[0] = $signed({prod_reg[0][ProdW-1], prod_reg[0]})
                  - $signed({prod_reg[1][ProdW-1], prod_reg[1]});
        n_next[1] = $signed({prod_reg[2][ProdW-1], prod_reg[2]})
                  - $signed({prod_reg[3][ProdW-1], prod_reg[3]});
        n_next[2] = $signed({prod_reg[4][ProdW-1], prod_reg[4]})
                  - $signed({prod_reg[5][ProdW-1], prod_reg[5]});
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[1:0], vld_in};
    end

    // data stages
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                a_reg[i] <= a_next[i];
                b_reg[i] <= b_next[i];
            end
            prod_reg[0] <= a_reg[1] * b_reg[2];
            prod_reg[1] <= a_reg[2] * b_reg[1];
            prod_reg[2] <= a_reg[2] * b_reg[0];
            prod_reg[3] <= a_reg[0] * b_reg[2];
            prod_reg[4] <= a_reg[0] * b_reg[1];
            prod_reg[5] <= a_reg[1] * b_reg[0];
            for (int i = 0; i < 3; i++)
            begin
                neg_reg[i] <= n_next[i][CrossW-1];
                if (n_next[i][CrossW-1])
                    mag_reg[i] <= MagW'(-n_next[i]);
                else
                    mag_reg[i] <= MagW'(n_next[i]);
            end
        end
    end

    assign vld_out = vld_reg[2];
    assign mag     = mag_reg;
    assign neg     = neg_reg;

endmodule

### design/tfn_norm.sv
// ---------------------------------------------------------------------------
// tfn_norm
// Common block scaling of the magnitudes, then sum of squares, five stages.
// ---------------------------------------------------------------------------
module tfn_norm
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  en,
    input  logic                                  vld_in,
    input  logic [2:0][tfn_pkg::MagW-1:0]         mag,
    input  logic [2:0]                            neg,
    output logic                                  vld_out,
    output logic [tfn_pkg::SumW-1:0]              sum,
    output tfn_pkg::tfn_side_t                    side
);
    import tfn_pkg::*;

    logic [4:0]            vld_reg;
    // stage D
    logic [MagW-1:0]       max_reg;
    logic [2:0][MagW-1:0]  mag_d_reg;
    logic [2:0]            neg_d_reg;
    logic [MagW-1:0]       max_next;
    // stage E
    logic [2:0][MagW-1:0]  mag_e_reg;
    logic [2:0]            neg_e_reg;
    logic                  degen_e_reg;
    logic                  right_reg;
    logic [ShiftW-1:0]     amt_reg;
    logic [ShiftW-1:0]     msb_next;
    // stage F, G, H
    tfn_side_t             side_f_reg;
    tfn_side_t             side_g_reg;
    tfn_side_t             side_h_reg;
    logic [2:0][NormW-1:0] m_next;
    logic [2:0][SqW-1:0]   sq_reg;
    logic [SumW-1:0]       sum_reg;

    // largest magnitude
    always_comb
    begin
        max_next = mag[0];
        if (mag[1] > max_next)
            max_next = mag[1];
        if (mag[2] > max_next)
            max_next = mag[2];
    end

    // leading one of the largest magnitude
    always_comb
    begin
        msb_next = '0;
        for (int i = 0; i < MagW; i++)
        begin
            if (max_reg[i])
                msb_next = ShiftW'(i);
        end
    end

    // shared shift of all three components
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            if (right_reg)
                m_next[i] = NormW'(mag_e_reg[i] >> amt_reg);
            else
                m_next[i] = NormW'(mag_e_reg[i] << amt_reg);
        end
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[3:0], vld_in};
    end

    // data stages
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            max_reg     <= max_next;
            mag_d_reg   <= mag;
            neg_d_reg   <= neg;

            mag_e_reg   <= mag_d_reg;
            neg_e_reg   <= neg_d_reg;
            degen_e_reg <= (max_reg == '0);
            right_reg   <= (msb_next > ShiftW'(NormTop));
            if (msb_next > ShiftW'(NormTop))
                amt_reg <= msb_next - ShiftW'(NormTop);
            else
                amt_reg <= ShiftW'(NormTop) - msb_next;

            side_f_reg.neg   <= neg_e_reg;
            side_f_reg.degen <= degen_e_reg;
            side_f_reg.m     <= m_next;

            side_g_reg <= side_f_reg;
            for (int i = 0; i < 3; i++)
                sq_reg[i] <= side_f_reg.m[i] * side_f_reg.m[i];

            side_h_reg <= side_g_reg;
            sum_reg    <= SumW'(sq_reg[0]) + SumW'(sq_reg[1]) + SumW'(sq_reg[2]);
        end
    end

    assign vld_out = vld_reg[4];
    assign sum     = sum_reg;
    assign side    = side_h_reg;

endmodule

### design/tfn_sqrt.sv
// ---------------------------------------------------------------------------
// tfn_sqrt
// Integer square root, one result bit per pipeline stage.
// ---------------------------------------------------------------------------
module tfn_sqrt
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  en,
    input  logic                                  vld_in,
    input  logic [tfn_pkg::SumW-1:0]              sum,
    input  tfn_pkg::tfn_side_t                    side_in,
    output logic                                  vld_out,
    output logic [tfn_pkg::RootW-1:0]             root,
    output tfn_pkg::tfn_side_t                    side_out
);
    import tfn_pkg::*;

    logic [RemW-1:0]  rem_reg  [RootW];
    logic [RootW-1:0] root_reg [RootW];
    logic [SumW-1:0]  s_reg    [RootW];
    tfn_side_t        side_reg [RootW];
    logic [RootW-1:0] vld_reg;
    logic [RemW-1:0]  rem_next  [RootW];
    logic [RootW-1:0] root_next [RootW];

    // one radicand bit pair per stage, most significant first
    always_comb
    begin
        logic [RemW-1:0]  rem_in;
        logic [RootW-1:0] root_in;
        logic [SumW-1:0]  s_in;
        logic [RemW-1:0]  rem_sh;
        logic [RemW-1:0]  trial;
        for (int k = 0; k < RootW; k++)
        begin
            if (k == 0)
            begin
                rem_in  = '0;
                root_in = '0;
                s_in    = sum;
            end
            else
            begin
                rem_in  = rem_reg[k-1];
                root_in = root_reg[k-1];
                s_in    = s_reg[k-1];
            end
            rem_sh = {rem_in[RemW-3:0], s_in[2*(RootW-1-k) +: 2]};
            trial  = {root_in, 2'b01};
            if (rem_sh >= trial)
            begin
                rem_next[k]  = rem_sh - trial;
                root_next[k] = {root_in[RootW-2:0], 1'b1};
            end
            else
            begin
                rem_next[k]  = rem_sh;
                root_next[k] = {root_in[RootW-2:0], 1'b0};
            end
        end
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[RootW-2:0], vld_in};
    end

    // stage registers
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < RootW; k++)
            begin
                rem_reg[k]  <= rem_next[k];
                root_reg[k] <= root_next[k];
                if (k == 0)
                begin
                    s_reg[k]    <= sum;
                    side_reg[k] <= side_in;
                end
                else
                begin
                    s_reg[k]    <= s_reg[k-1];
                    side_reg[k] <= side_reg[k-1];
                end
            end
        end
    end

    assign vld_out  = vld_reg[RootW-1];
    assign root     = root_reg[RootW-1];
    assign side_out = side_reg[RootW-1];

endmodule

### design/tfn_div.sv
// ---------------------------------------------------------------------------
// tfn_div
// Rounded division of each magnitude by the length, clamp, sign, degenerate zeroing and output.
// ---------------------------------------------------------------------------
module tfn_div
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  en,
    input  logic                                  vld_in,
    input  logic [tfn_pkg::RootW-1:0]             len,
    input  tfn_pkg::tfn_side_t                    side,
    output logic                                  vld_out,
    output logic [2:0][tfn_pkg::UnitW-1:0]        unit,
    output logic                                  degen
);
    import tfn_pkg::*;

    localparam int Steps = QuotW + 1;

    logic [2:0][DivRemW-1:0] rem_reg  [Steps];
    logic [2:0][QuotW-1:0]   low_reg  [Steps];
    logic [2:0][QuotW-1:0]   q_reg    [Steps];
    logic [RootW-1:0]        len_reg  [Steps];
    logic [2:0]              neg_reg  [Steps];
    logic                    dg_reg   [Steps];
    logic [Steps:0]          vld_reg;
    logic [2:0][DivRemW-1:0] rem_next [Steps];
    logic [2:0][QuotW-1:0]   q_next   [Steps];
    logic [2:0][UnitW-1:0]   unit_next;
    logic [2:0][UnitW-1:0]   unit_reg;
    logic                    degen_reg;

    // numerator setup then one quotient bit per stage
    always_comb
    begin
        logic [NumW-1:0]    num;
        logic [DivRemW-1:0] rem_sh;
        for (int c = 0; c < 3; c++)
        begin
            num = {1'b0, side.m[c], FracBits'(0)} + NumW'(len >> 1);
            rem_next[0][c] = DivRemW'(num[NumW-1:QuotW]);
            q_next[0][c]   = '0;
            for (int k = 1; k < Steps; k++)
            begin
                rem_sh = {rem_reg[k-1][c][DivRemW-2:0], low_reg[k-1][c][QuotW-k]};
                if (rem_sh >= {1'b0, len_reg[k-1]})
                begin
                    rem_next[k][c] = rem_sh - {1'b0, len_reg[k-1]};
                    q_next[k][c]   = {q_reg[k-1][c][QuotW-2:0], 1'b1};
                end
                else
                begin
                    rem_next[k][c] = rem_sh;
                    q_next[k][c]   = {q_reg[k-1][c][QuotW-2:0], 1'b0};
                end
            end
        end
    end

    // clamp to one, apply sign, zero degenerate faces
    always_comb
    begin
        logic [UnitW-1:0] u;
        for (int c = 0; c < 3; c++)
        begin
            u = (q_reg[Steps-1][c] > UnitOne) ? UnitOne : q_reg[Steps-1][c];
            if (dg_reg[Steps-1])
                unit_next[c] = '0;
            else if (neg_reg[Steps-1][c])
                unit_next[c] = -u;
            else
                unit_next[c] = u;
        end
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[Steps-1:0], vld_in};
    end

    // stage registers
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < Steps; k++)
            begin
                rem_reg[k] <= rem_next[k];
                q_reg[k]   <= q_next[k];
                if (k == 0)
                begin
                    for (int c = 0; c < 3; c++)
                        low_reg[k][c] <= QuotW'({side.m[c], FracBits'(0)}
                                         + NumW'(len >> 1));
                    len_reg[k] <= len;
                    neg_reg[k] <= side.neg;
                    dg_reg[k]  <= side.degen;
                end
                else
                begin
                    low_reg[k] <= low_reg[k-1];
                    len_reg[k] <= len_reg[k-1];
                    neg_reg[k] <= neg_reg[k-1];
                    dg_reg[k]  <= dg_reg[k-1];
                end
            end
            unit_reg  <= unit_next;
            degen_reg <= dg_reg[Steps-1];
        end
    end

    assign vld_out = vld_reg[Steps];
    assign unit    = unit_reg;
    assign degen   = degen_reg;

endmodule

### design/triangle_face_unit_normal.sv
// Stages: 3 cross product, 5 scaling, 31 square root, 18 divide and output.
// Throughput: one face per cycle; the whole pipeline holds while a result
// waits on out_ready, so in_ready follows out_ready with no register between.
// Reset: rst_n clears all valid bits asynchronously; payload is not reset.
// ---------------------------------------------------------------------------
// triangle_face_unit_normal
// Cross product of two triangle edges, scaled to a Q1.14 unit normal.
// ---------------------------------------------------------------------------
module triangle_face_unit_normal
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic signed [tfn_pkg::CoordW-1:0]    p0_x,
    input  logic signed [tfn_pkg::CoordW-1:0]    p0_y,
    input  logic signed [tfn_pkg::CoordW-1:0]    p0_z,
    input  logic signed [tfn_pkg::CoordW-1:0]    p1_x,
    input  logic signed [tfn_pkg::CoordW-1:0]    p1_y,
    input  logic signed [tfn_pkg::CoordW-1:0]    p1_z,
    input  logic signed [tfn_pkg::CoordW-1:0]    p2_x,
    input  logic signed [tfn_pkg::CoordW-1:0]    p2_y,
    input  logic signed [tfn_pkg::CoordW-1:0]    p2_z,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic signed [tfn_pkg::UnitW-1:0]     unit_x,
    output logic signed [tfn_pkg::UnitW-1:0]     unit_y,
    output logic signed [tfn_pkg::UnitW-1:0]     unit_z,
    output logic                                 degenerate
);
    import tfn_pkg::*;

    logic                  en;
    logic [8:0][CoordW-1:0] pts;
    logic                  cross_vld;
    logic [2:0][MagW-1:0]  mag;
    logic [2:0]            neg;
    logic                  norm_vld;
    logic [SumW-1:0]       sum;
    tfn_side_t             norm_side;
    logic                  sqrt_vld;
    logic [RootW-1:0]      root;
    tfn_side_t             sqrt_side;
    logic [2:0][UnitW-1:0] unit;

    // pipeline advances unless a finished result is held
    assign en       = !out_valid || out_ready;
    assign in_ready = en;

    assign pts = {p2_z, p2_y, p2_x, p1_z, p1_y, p1_x, p0_z, p0_y, p0_x};

    tfn_cross u_cross
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .vld_in  (in_valid),
        .pts     (pts),
        .vld_out (cross_vld),
        .mag     (mag),
        .neg     (neg)
    );

    tfn_norm u_norm
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .vld_in  (cross_vld),
        .mag     (mag),
        .neg     (neg),
        .vld_out (norm_vld),
        .sum     (sum),
        .side    (norm_side)
    );

    tfn_sqrt u_sqrt
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .vld_in   (norm_vld),
        .sum      (sum),
        .side_in  (norm_side),
        .vld_out  (sqrt_vld),
        .root     (root),
        .side_out (sqrt_side)
    );

    tfn_div u_div
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .vld_in  (sqrt_vld),
        .len     (root),
        .side    (sqrt_side),
        .vld_out (out_valid),
        .unit    (unit),
        .degen   (degenerate)
    );

    assign unit_x = unit[0];
    assign unit_y = unit[1];
    assign unit_z = unit[2];

endmodule

### design/tfn_checker.sv
// ---------------------------------------------------------------------------
// tfn_checker
// Port-level checks on the unit normal block, bound to the top level.
// ---------------------------------------------------------------------------
module tfn_checker
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_ready,
    input  logic                                 out_valid,
    input  logic                                 out_ready,
    input  logic signed [tfn_pkg::UnitW-1:0]     unit_x,
    input  logic signed [tfn_pkg::UnitW-1:0]     unit_y,
    input  logic signed [tfn_pkg::UnitW-1:0]     unit_z,
    input  logic                                 degenerate
);
    import tfn_pkg::*;

    // a held result keeps its payload
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(unit_x)
            && $stable(unit_y) && $stable(unit_z) && $stable(degenerate))
    else $error("held result changed");

    // degenerate faces give a zero normal
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && degenerate |-> unit_x == 0 && unit_y == 0 && unit_z == 0)
    else $error("degenerate result not zero");

    // components stay within plus or minus one
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> unit_x >= -16384 && unit_x <= 16384
            && unit_y >= -16384 && unit_y <= 16384
            && unit_z >= -16384 && unit_z <= 16384)
    else $error("unit component out of range");

    // a stalled output stops input transfers
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |-> !in_ready)
    else $error("input taken during output stall");

    // an empty output register never blocks input
    assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
    else $error("input blocked with empty output");

endmodule

bind triangle_face_unit_normal tfn_checker u_tfn_checker
(
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ready   (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .unit_x     (unit_x),
    .unit_y     (unit_y),
    .unit_z     (unit_z),
    .degenerate (degenerate)
);

### test/testbench.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// testbench
// Checks the triangle face unit normal block: directed faces from a table,
// then random faces, each compared with an in-bench normal predictor.
// ---------------------------------------------------------------------------
module testbench;

    import tfn_pkg::*;

    localparam int LatencyCycles = 57;
    localparam int RandomFaces   = 1400;
    localparam int CalmFaces     = 200;
    localparam int WatchdogLimit = 4000;

    typedef logic signed [CoordW-1:0] coord_t;
    typedef logic signed [UnitW-1:0]  unit_t;

    typedef struct packed {
        coord_t p0x, p0y, p0z, p1x, p1y, p1z, p2x, p2y, p2z;
    } face_t;

    typedef struct packed {
        unit_t ux, uy, uz;
        logic  degen;
    } normal_t;

    typedef struct packed {
        face_t   face;
        logic    typed;
        normal_t want;
    } face_row_t;

    logic   clk;
    logic   rst_n;
    logic   in_valid;
    logic   in_ready;
    coord_t p0_x, p0_y, p0_z, p1_x, p1_y, p1_z, p2_x, p2_y, p2_z;
    logic   out_valid;
    logic   out_ready;
    unit_t  unit_x, unit_y, unit_z;
    logic   degenerate;

    normal_t   normal_queue[$];
    face_row_t face_rows[$];
    int        fail_count;
    int        result_count;
    int        idle_cycles;
    bit        calm;
    bit        sending_done;

    triangle_face_unit_normal dut
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .p0_x       (p0_x),
        .p0_y       (p0_y),
        .p0_z       (p0_z),
        .p1_x       (p1_x),
        .p1_y       (p1_y),
        .p1_z       (p1_z),
        .p2_x       (p2_x),
        .p2_y       (p2_y),
        .p2_z       (p2_z),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .unit_x     (unit_x),
        .unit_y     (unit_y),
        .unit_z     (unit_z),
        .degenerate (degenerate)
    );

    // clock
    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // integer square root, bit by bit
    function automatic longint unsigned root_floor(longint unsigned s);
        longint unsigned res;
        longint unsigned bitv;
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > s)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (s >= res + bitv)
            begin
                s   = s - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
                res = res >> 1;
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // unit normal of one face
    function automatic normal_t face_normal(face_t f);
        longint          ax, ay, az, bx, by, bz;
        longint          n[3];
        longint unsigned m[3];
        longint unsigned top, s, len, u;
        normal_t         r;
        ax = longint'(f.p1x) - longint'(f.p0x);
        ay = longint'(f.p1y) - longint'(f.p0y);
        az = longint'(f.p1z) - longint'(f.p0z);
        bx = longint'(f.p2x) - longint'(f.p1x);
        by = longint'(f.p2y) - longint'(f.p1y);
        bz = longint'(f.p2z) - longint'(f.p1z);
        n[0] = ay * bz - az * by;
        n[1] = az * bx - ax * bz;
        n[2] = ax * by - ay * bx;
        for (int i = 0; i < 3; i++)
            m[i] = (n[i] < 0) ? longint'(-n[i]) : longint'(n[i]);
        top = m[0];
        if (m[1] > top) top = m[1];
        if (m[2] > top) top = m[2];
        r = '0;
        if (top == 0)
        begin
            r.degen = 1'b1;
            return r;
        end
        // bring the largest magnitude into [2^29, 2^30)
        while (top >= (64'd1 << 30))
        begin
            top = top >> 1;
            for (int i = 0; i < 3; i++) m[i] = m[i] >> 1;
        end
        while (top < (64'd1 << 29))
        begin
            top = top << 1;
            for (int i = 0; i < 3; i++) m[i] = m[i] << 1;
        end
        s   = m[0] * m[0] + m[1] * m[1] + m[2] * m[2];
        len = root_floor(s);
        if (len == 0) len = 1;
        for (int i = 0; i < 3; i++)
        begin
            u = (m[i] * 64'd16384 + (len >> 1)) / len;
            if (u > 64'd16384) u = 64'd16384;
            if (n[i] < 0) u = -u;
            if (i == 0) r.ux = unit_t'(u);
            else if (i == 1) r.uy = unit_t'(u);
            else r.uz = unit_t'(u);
        end
        return r;
    endfunction

    function automatic face_t make_face(int a, int b, int c, int d, int e, int f2,
                                        int g, int h, int k);
        face_t f;
        f = {coord_t'(a), coord_t'(b), coord_t'(c), coord_t'(d), coord_t'(e),
             coord_t'(f2), coord_t'(g), coord_t'(h), coord_t'(k)};
        return f;
    endfunction

    function automatic coord_t random_coord();
        case ($urandom_range(0, 5))
            0: return coord_t'(16'sh8000);
            1: return coord_t'(16'sh7fff);
            2: return coord_t'(int'($urandom_range(0, 15)) - 8);
            default: return coord_t'($urandom);
        endcase
    endfunction

    function automatic face_t random_face();
        face_t f;
        int    kind;
        f    = {random_coord(), random_coord(), random_coord(), random_coord(),
                random_coord(), random_coord(), random_coord(), random_coord(),
                random_coord()};
        kind = $urandom_range(0, 9);
        // repeated vertex or collinear points
        if (kind == 0)
            {f.p1x, f.p1y, f.p1z} = {f.p0x, f.p0y, f.p0z};
        else if (kind == 1)
        begin
            f.p1x = coord_t'(f.p0x + 1);
            f.p1y = coord_t'(f.p0y + 2);
            f.p1z = coord_t'(f.p0z + 3);
            f.p2x = coord_t'(f.p1x + 1);
            f.p2y = coord_t'(f.p1y + 2);
            f.p2z = coord_t'(f.p1z + 3);
        end
        return f;
    endfunction

    // directed rows
    task automatic add_row(face_t f, logic typed, normal_t want);
        face_row_t r;
        r = '{face: f, typed: typed, want: want};
        face_rows.insert(face_rows.size(), r);
    endtask

    // append one prediction
    task automatic expect_normal(normal_t n);
        normal_queue.insert(normal_queue.size(), n);
    endtask

    task automatic send_face(face_t f);
        in_valid <= 1'b1;
        {p0_x, p0_y, p0_z, p1_x, p1_y, p1_z, p2_x, p2_y, p2_z} <= f;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        expect_normal(face_normal(f));
    endtask

    task automatic sender_gap();
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
    endtask

    // stimulus
    initial
    begin
        face_row_t row;
        normal_t   none;
        none         = '0;
        fail_count   = 0;
        result_count = 0;
        calm         = 1'b0;
        sending_done = 1'b0;
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        {p0_x, p0_y, p0_z, p1_x, p1_y, p1_z, p2_x, p2_y, p2_z} = '0;

        // faces whose normal is obvious
        add_row(make_face(0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1, '{0, 0, 0, 1'b1});
        add_row(make_face(100, 200, 300, 100, 200, 300, 5, 6, 7), 1'b1,
                '{0, 0, 0, 1'b1});
        add_row(make_face(0, 0, 0, 1, 1, 1, 2, 2, 2), 1'b1, '{0, 0, 0, 1'b1});
        add_row(make_face(0, 0, 0, 4096, 0, 0, 4096, 4096, 0), 1'b1,
                '{0, 0, 16384, 1'b0});
        add_row(make_face(0, 0, 0, 0, 4096, 0, 4096, 4096, 0), 1'b1,
                '{0, 0, -16384, 1'b0});
        add_row(make_face(0, 0, 0, 0, 1, 0, 0, 1, 1), 1'b1, '{16384, 0, 0, 1'b0});
        add_row(make_face(0, 0, 0, 0, 0, 1, 1, 0, 1), 1'b1, '{0, 16384, 0, 1'b0});
        add_row(make_face(-32768, -32768, -32768, 32767, -32768, -32768,
                          32767, 32767, -32768), 1'b1, '{0, 0, 16384, 1'b0});
        add_row(make_face(32767, 32767, 32767, 32767, 32767, 32767,
                          32767, 32767, 32767), 1'b1, '{0, 0, 0, 1'b1});
        // extremes and oblique faces, predicted
        add_row(make_face(-32768, 32767, -32768, 32767, -32768, 32767,
                          -32768, -32768, 32767), 1'b0, none);
        add_row(make_face(32767, 32767, -32768, -32768, 32767, 32767,
                          32767, -32768, 32767), 1'b0, none);
        add_row(make_face(0, 0, 0, 1, 0, 0, 0, 1, 0), 1'b0, none);
        add_row(make_face(0, 0, 0, 1, 2, 3, -4, 5, -6), 1'b0, none);
        add_row(make_face(-1, -1, -1, 32767, 0, -32768, 0, 32767, 12345), 1'b0, none);
        add_row(make_face(1000, -2000, 3000, -4000, 5000, -6000, 7000, 8000, -9000),
                1'b0, none);
        add_row(make_face(-32768, 0, 0, 0, -32768, 0, 0, 0, -32768), 1'b0, none);

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (face_rows[i])
        begin
            row = face_rows[i];
            send_face(row.face);
            if (row.typed && row.want != normal_queue[$])
            begin
                $display("%0t: table row %0d expected %0d %0d %0d %b predictor %0d %0d %0d %b",
                         $time, i, row.want.ux, row.want.uy, row.want.uz,
                         row.want.degen, normal_queue[$].ux, normal_queue[$].uy,
                         normal_queue[$].uz, normal_queue[$].degen);
                fail_count++;
            end
            if (row.typed)
                normal_queue[$] = row.want;
        end

        for (int i = 0; i < RandomFaces; i++)
        begin
            if (i == RandomFaces / 2)
            begin
                // let the pipeline drain completely
                in_valid <= 1'b0;
                while (normal_queue.size() != 0)
                    @(posedge clk);
            end
            if (i == RandomFaces - CalmFaces)
                calm = 1'b1;
            sender_gap();
            send_face(random_face());
        end
        in_valid <= 1'b0;
        sending_done = 1'b1;
    end

    // receiver stalls
    initial
    begin
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (!calm && $urandom_range(0, 3) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 16)) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
        end
    end

    // compare each result transfer with the oldest prediction
    always @(posedge clk)
    begin
        normal_t got;
        normal_t want;
        if (rst_n && out_valid && out_ready)
        begin
            got = '{unit_x, unit_y, unit_z, degenerate};
            result_count++;
            if (normal_queue.size() == 0)
            begin
                $display("%0t: unexpected result %0d %0d %0d %b", $time,
                         unit_x, unit_y, unit_z, degenerate);
                fail_count++;
            end
            else
            begin
                want = normal_queue.pop_front();
                if (got.ux !== want.ux)
                begin
                    $display("%0t: unit_x expected %0d got %0d", $time, want.ux, got.ux);
                    fail_count++;
                end
                if (got.uy !== want.uy)
                begin
                    $display("%0t: unit_y expected %0d got %0d", $time, want.uy, got.uy);
                    fail_count++;
                end
                if (got.uz !== want.uz)
                begin
                    $display("%0t: unit_z expected %0d got %0d", $time, want.uz, got.uz);
                    fail_count++;
                end
                if (got.degen !== want.degen)
                begin
                    $display("%0t: degenerate expected %b got %b", $time,
                             want.degen, got.degen);
                    fail_count++;
                end
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        wait (sending_done);
        while (normal_queue.size() != 0 && idle_cycles < WatchdogLimit)
            @(posedge clk);
        if (normal_queue.size() != 0)
        begin
            $display("TB_ERROR");
            $finish;
        end
        else
        begin
            repeat (LatencyCycles + 10) @(posedge clk);
            $display("ran %0d faces: table rows, degenerate, axis and extreme faces,",
                     face_rows.size() + RandomFaces);
            $display("random faces with stalls on both sides; %0d results checked",
                     result_count);
            if (fail_count == 0)
                $display("TB_OK");
            else
                $display("TB_ERROR");
            $finish;
        end
    end

    // timeout guard on cycles without any transfer while sending
    initial
    begin
        wait (idle_cycles >= WatchdogLimit);
        if (!sending_done)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

endmodule

### sim.f
design/tfn_pkg.sv
design/tfn_cross.sv
design/tfn_norm.sv
design/tfn_sqrt.sv
design/tfn_div.sv
design/triangle_face_unit_normal.sv
design/tfn_checker.sv
test/testbench.sv
